FILE: design/psw_pkg.sv
// Package for the phase-aware session watchdog.
// Holds the beat types, function and action codes and the timeout lookup.
// Used by every module in the design folder; depends on nothing.
`default_nettype none

package psw_pkg;

  localparam int unsigned LEAD_W    = 20;
  localparam int unsigned TIMEOUT_W = 19;

  localparam logic [2:0] FUNC_CHECK    = 3'd0;
  localparam logic [2:0] FUNC_KICK     = 3'd1;
  localparam logic [2:0] FUNC_PHASE    = 3'd2;
  localparam logic [2:0] FUNC_APPSTATE = 3'd3;
  localparam logic [2:0] FUNC_CONNECT  = 3'd4;
  localparam logic [2:0] FUNC_DISCONN  = 3'd5;
  localparam logic [2:0] FUNC_COMPLETE = 3'd6;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_WARN    = 2'd1;
  localparam logic [1:0] ACT_DROP    = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_STARTING   = 3'd1;
  localparam logic [2:0] PH_SELECTING  = 3'd2;
  localparam logic [2:0] PH_TYPING     = 3'd3;
  localparam logic [2:0] PH_CLAIM      = 3'd4;
  localparam logic [2:0] PH_SENDING    = 3'd5;
  localparam logic [2:0] PH_CONNECTING = 3'd6;
  localparam logic [2:0] PH_DONE       = 3'd7;

  localparam logic [15:0]         HANDLE_NONE = 16'hFFFF;
  localparam logic [LEAD_W-1:0]   LEAD_RESET  = 20'd10000;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
    logic [2:0]  phase_value;
    logic        foreground;
    logic [15:0] link_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [15:0]          drop_handle;
    logic [TIMEOUT_W-1:0] current_timeout_ms;
    logic [31:0]          idle_ms;
  } out_item_t;

  // Item held in the input stage, passed to the core.
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } staged_t;

  function automatic logic [TIMEOUT_W-1:0] timeout_lookup(input logic [2:0] ph,
                                                          input logic front);
    logic [TIMEOUT_W-1:0] t;
    t = 19'd20000;
    if (front) begin
      case (ph)
        PH_IDLE:       t = 19'd60000;
        PH_STARTING:   t = 19'd60000;
        PH_SELECTING:  t = 19'd180000;
        PH_TYPING:     t = 19'd300000;
        PH_CLAIM:      t = 19'd60000;
        PH_SENDING:    t = 19'd60000;
        PH_CONNECTING: t = 19'd90000;
        PH_DONE:       t = 19'd20000;
        default:       t = 19'd20000;
      endcase
    end else begin
      case (ph)
        PH_IDLE:       t = 19'd20000;
        PH_STARTING:   t = 19'd20000;
        PH_SELECTING:  t = 19'd30000;
        PH_TYPING:     t = 19'd30000;
        PH_CLAIM:      t = 19'd15000;
        PH_SENDING:    t = 19'd20000;
        PH_CONNECTING: t = 19'd30000;
        PH_DONE:       t = 19'd20000;
        default:       t = 19'd20000;
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: design/psw_in_reg.sv
// Input stage of the watchdog: registers one beat from the input channel.
// Depends on psw_pkg for the beat types.
`default_nettype none

module psw_in_reg import psw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  output logic          in_stall,
  input  wire logic     adv,
  output staged_t       stg
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;
  logic     take;

  // The stage refills in the same cycle that its beat moves on.
  assign in_stall = vld_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  assign stg.vld  = vld_r;
  assign stg.item = item_r;

endmodule

`default_nettype wire

FILE: design/psw_core.sv
// Session state and decision logic of the watchdog.
// Updates the state and forms one result per staged beat; depends on psw_pkg.
`default_nettype none

module psw_core import psw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [LEAD_W-1:0] cfg_wr_data,
  input  wire staged_t           stg,
  input  wire logic              adv,
  output out_item_t             res
);

  logic [LEAD_W-1:0] lead_r;
  logic [2:0]        phase_r, phase_nxt;
  logic              front_r, front_nxt;
  logic              enabled_r, enabled_nxt;
  logic              link_r, link_nxt;
  logic [15:0]       handle_r, handle_nxt;
  logic [31:0]       last_r, last_nxt;
  logic              warned_r, warned_nxt;

  logic [31:0]          idle;
  logic [TIMEOUT_W-1:0] to_cur;
  logic [32:0]          lead_sum;
  logic                 warn_due;
  logic                 expired;
  logic [1:0]           action;
  in_item_t             it;

  assign it       = stg.item;
  assign idle     = it.now_ms - last_r;
  assign to_cur   = timeout_lookup(phase_r, front_r);
  assign lead_sum = {1'b0, idle} + {13'd0, lead_r};
  assign warn_due = !warned_r && (lead_sum > {14'd0, to_cur}) && (idle < {13'd0, to_cur});
  assign expired  = idle > {13'd0, to_cur};

  always_comb begin
    phase_nxt   = phase_r;
    front_nxt   = front_r;
    enabled_nxt = enabled_r;
    link_nxt    = link_r;
    handle_nxt  = handle_r;
    last_nxt    = last_r;
    warned_nxt  = warned_r;
    action      = ACT_NONE;
    case (it.func)
      FUNC_CHECK: begin
        if (enabled_r && link_r) begin
          if (warn_due) begin
            action     = ACT_WARN;
            warned_nxt = 1'b1;
          end else if (expired) begin
            action     = (handle_r != HANDLE_NONE) ? ACT_DROP : ACT_RESTART;
            last_nxt   = it.now_ms;
            warned_nxt = 1'b0;
          end
        end
      end
      FUNC_KICK: begin
        last_nxt   = it.now_ms;
        warned_nxt = 1'b0;
      end
      FUNC_PHASE: begin
        phase_nxt  = it.phase_value;
        last_nxt   = it.now_ms;
        warned_nxt = 1'b0;
      end
      FUNC_APPSTATE: begin
        front_nxt  = it.foreground;
        last_nxt   = it.now_ms;
        warned_nxt = 1'b0;
      end
      FUNC_CONNECT: begin
        link_nxt    = 1'b1;
        handle_nxt  = it.link_handle;
        front_nxt   = 1'b1;
        phase_nxt   = PH_STARTING;
        enabled_nxt = 1'b1;
        last_nxt    = it.now_ms;
        warned_nxt  = 1'b0;
      end
      FUNC_DISCONN: begin
        link_nxt    = 1'b0;
        handle_nxt  = HANDLE_NONE;
        phase_nxt   = PH_IDLE;
        front_nxt   = 1'b1;
        enabled_nxt = 1'b0;
        last_nxt    = it.now_ms;
        warned_nxt  = 1'b0;
      end
      FUNC_COMPLETE: begin
        enabled_nxt = 1'b0;
        link_nxt    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // The result reports the handle and timeout as they stand after the beat.
  assign res.action             = action;
  assign res.drop_handle        = handle_nxt;
  assign res.current_timeout_ms = timeout_lookup(phase_nxt, front_nxt);
  assign res.idle_ms            = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r    <= LEAD_RESET;
      phase_r   <= PH_IDLE;
      front_r   <= 1'b1;
      enabled_r <= 1'b0;
      link_r    <= 1'b0;
      handle_r  <= HANDLE_NONE;
      last_r    <= 32'd0;
      warned_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lead_r <= cfg_wr_data;
      end
      if (adv) begin
        phase_r   <= phase_nxt;
        front_r   <= front_nxt;
        enabled_r <= enabled_nxt;
        link_r    <= link_nxt;
        handle_r  <= handle_nxt;
        last_r    <= last_nxt;
        warned_r  <= warned_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/phase_aware_session_watchdog.sv
// Session idle watchdog, top level: input stage, decision core, result register.
// Depends on psw_pkg, psw_in_reg and psw_core.
//
// Use: every input beat carries a function code and a millisecond time stamp;
// each beat gives exactly one result beat with the action to take, the held
// handle, the timeout in force and the idle time measured.
// Channels: in_valid/in_stall/in_data in, out_valid/out_stall/out_data out.
// A beat moves at a clock edge where valid is high and stall is low.
// The pre-warning lead is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// A result passes the input register, then the result register, before it
// leaves. Throughput: one beat per cycle while out_stall is low, since the
// state update for a beat is two lookups, one subtraction, one addition and
// four compares between the input register and the result register.
// Stall: when out_stall holds a full result register, the input stage holds
// its beat and raises in_stall once it is full; no beat is lost.
// Reset (rst_n low, synchronous): both stages empty, session idle, phase
// idle, foreground, no handle, lead back to 10000 ms.
`default_nettype none

module phase_aware_session_watchdog import psw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [LEAD_W-1:0] cfg_wr_data
);

  staged_t   stg;
  out_item_t res;
  logic      adv;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_data_r;

  // A staged beat moves on whenever the result register is free or emptying.
  assign adv = stg.vld && (!out_vld_r || !out_stall);

  psw_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .adv      (adv),
    .stg      (stg)
  );

  psw_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stg         (stg),
    .adv         (adv),
    .res         (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A beat that leaves the input stage always lands in the result register.
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("staged beat did not reach the result register");

  // The input stage only stalls while it holds a beat that cannot move.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stg.vld && out_valid && out_stall))
    else $error("input stall without a blocked beat");

  // A disconnect order never names the empty handle.
  a_drop_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action == ACT_DROP) |-> (out_data.drop_handle != HANDLE_NONE))
    else $error("disconnect ordered without a handle");

  // Nothing is offered on the result side straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
